### sv/rom_bank_mapper_with_irq_core_macros.svh
// assertion helpers for the bank mapper
`ifndef ROM_BANK_MAPPER_WITH_IRQ_CORE_MACROS_SVH
`define ROM_BANK_MAPPER_WITH_IRQ_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define RBM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define RBM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/rbm_pkg.sv
package rbm_pkg;

   // item kinds
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_PRG   = 2'd2;
   localparam logic [1:0] CMD_CHR   = 2'd3;

   // lookup targets
   localparam logic [1:0] TGT_PRG  = 2'd0;
   localparam logic [1:0] TGT_WRAM = 2'd1;
   localparam logic [1:0] TGT_NONE = 2'd2;
   localparam logic [1:0] TGT_CHR  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_EXTENDED_MODE   = 2'd0;
   localparam logic [1:0] CSR_PRG_BANK_COUNT  = 2'd1;
   localparam logic [1:0] CSR_WRAM_PRESENT    = 2'd2;
   localparam logic [1:0] CSR_MIRROR_AT_RESET = 2'd3;

   // configuration reset values
   localparam logic       EXTENDED_MODE_RESET   = 1'b1;
   localparam logic [5:0] PRG_BANK_COUNT_RESET  = 6'd32;
   localparam logic       WRAM_PRESENT_RESET    = 1'b1;
   localparam logic [1:0] MIRROR_AT_RESET_RESET = 2'd0;

   localparam logic [9:0] PRESCALE_RELOAD = 10'd341;
   localparam logic [9:0] PRESCALE_STEP   = 10'd3;
   localparam logic [7:0] IRQ_COUNT_WRAP  = 8'hFF;

   localparam int CHR_BANKS = 8;

   typedef struct packed {
      logic [4:0]                prg_first;
      logic [4:0]                prg_second;
      logic                      swap_mode;
      logic                      wram_enable;
      logic [1:0]                mirroring;
      logic [CHR_BANKS-1:0][8:0] chr;
      logic [7:0]                irq_reload;
      logic [7:0]                irq_count;
      logic [9:0]                irq_prescale;
      logic                      irq_every_tick;
      logic                      irq_enabled;
      logic                      irq_after_ack;
      logic                      irq_pending;
      logic                      ram_latch;
   } rbm_state_type;

   function automatic rbm_state_type reset_state();
      rbm_state_type s;
      s = '0;
      s.wram_enable = WRAM_PRESENT_RESET;
      s.mirroring   = MIRROR_AT_RESET_RESET;
      for (int i = 0; i < CHR_BANKS; i++) begin
         s.chr[i] = 9'(i);
      end
      return s;
   endfunction

   localparam rbm_state_type STATE_RESET = reset_state();

endpackage

### sv/rbm_regs.sv
module rbm_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [1:0]            cmd,
   input  logic [15:0]           addr,
   input  logic [7:0]            data,
   input  logic                  extended_mode,
   output rbm_pkg::rbm_state_type st,
   output rbm_pkg::rbm_state_type st_next
);
   import rbm_pkg::*;

   rbm_state_type st_ff, st_in;
   logic [1:0]    lo;
   logic [3:0]    hi;
   logic [2:0]    chr_idx;
   logic [4:0]    chr_high;
   logic [9:0]    pre_dec;
   logic          irq_clock;

   assign lo       = addr[1:0] | addr[3:2];
   assign hi       = addr[15:12];
   // 0xb000 -> banks 0/1, 0xc000 -> 2/3, 0xd000 -> 4/5, 0xe000 -> 6/7
   assign chr_idx  = {hi[1:0] - 2'd3, lo[1]};
   assign chr_high = extended_mode ? data[4:0] : {1'b0, data[3:0]};
   assign pre_dec  = st_ff.irq_prescale - PRESCALE_STEP;
   // zero or negative in ten-bit two's complement
   assign irq_clock = st_ff.irq_every_tick || (pre_dec == '0) || pre_dec[9];

   always_comb begin
      st_in = st_ff;
      if (fire) begin
         unique case (cmd)
            CMD_WRITE: begin
               if (addr[15:13] == 3'b011) begin
                  if (!extended_mode) begin
                     st_in.ram_latch = data[0];
                  end
               end else if (addr[15]) begin
                  case (hi)
                     4'h8: st_in.prg_first  = data[4:0];
                     4'hA: st_in.prg_second = data[4:0];
                     4'h9: begin
                        if (!extended_mode) begin
                           st_in.mirroring = {1'b0, data[0]};
                        end else if (lo == 2'd2) begin
                           st_in.wram_enable = data[0];
                           st_in.swap_mode   = data[1];
                        end else if (!lo[1]) begin
                           st_in.mirroring = data[1:0];
                        end
                     end
                     4'hF: begin
                        if (extended_mode) begin
                           case (lo)
                              2'd0: st_in.irq_reload[3:0] = data[3:0];
                              2'd1: st_in.irq_reload[7:4] = data[3:0];
                              2'd2: begin
                                 st_in.irq_prescale = PRESCALE_RELOAD;
                                 if (data[1]) begin
                                    st_in.irq_count = st_ff.irq_reload;
                                 end
                                 st_in.irq_every_tick = data[2];
                                 st_in.irq_enabled    = data[1];
                                 st_in.irq_after_ack  = data[0];
                                 st_in.irq_pending    = 1'b0;
                              end
                              default: begin
                                 st_in.irq_enabled = st_ff.irq_after_ack;
                                 st_in.irq_pending = 1'b0;
                              end
                           endcase
                        end
                     end
                     default: begin
                        if (!lo[0]) begin
                           st_in.chr[chr_idx][3:0] = data[3:0];
                        end else begin
                           st_in.chr[chr_idx][8:4] = chr_high;
                        end
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (extended_mode && st_ff.irq_enabled) begin
                  st_in.irq_prescale = pre_dec;
                  if (irq_clock) begin
                     if (st_ff.irq_count == IRQ_COUNT_WRAP) begin
                        st_in.irq_count   = st_ff.irq_reload;
                        st_in.irq_pending = 1'b1;
                     end else begin
                        st_in.irq_count = st_ff.irq_count + 8'd1;
                     end
                     st_in.irq_prescale = pre_dec + PRESCALE_RELOAD;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

   assign st      = st_ff;
   assign st_next = st_in;

endmodule

### sv/rbm_lookup.sv
module rbm_lookup (
   input  logic [1:0]             cmd,
   input  logic [15:0]            addr,
   input  logic                   extended_mode,
   input  logic [5:0]             prg_bank_count,
   input  rbm_pkg::rbm_state_type st,
   output logic [8:0]             bank,
   output logic [1:0]             target
);
   import rbm_pkg::*;

   logic       swapped;
   logic [5:0] fixed_last;
   logic [5:0] fixed_second;

   assign swapped      = extended_mode && st.swap_mode;
   assign fixed_last   = prg_bank_count - 6'd1;
   assign fixed_second = prg_bank_count - 6'd2;

   always_comb begin
      bank   = '0;
      target = TGT_NONE;
      unique case (cmd)
         CMD_PRG: begin
            case (addr[15:13])
               3'b011: target = st.wram_enable ? TGT_WRAM : TGT_NONE;
               3'b100: begin
                  target = TGT_PRG;
                  bank   = swapped ? {3'b0, fixed_second} : {4'b0, st.prg_first};
               end
               3'b101: begin
                  target = TGT_PRG;
                  bank   = {4'b0, st.prg_second};
               end
               3'b110: begin
                  target = TGT_PRG;
                  bank   = swapped ? {4'b0, st.prg_first} : {3'b0, fixed_second};
               end
               3'b111: begin
                  target = TGT_PRG;
                  bank   = {3'b0, fixed_last};
               end
               default: target = TGT_NONE;
            endcase
         end
         CMD_CHR: begin
            if (addr[15:13] == 3'b000) begin
               bank   = st.chr[addr[12:10]];
               target = TGT_CHR;
            end
         end
         default: ;
      endcase
   end

endmodule

### sv/rom_bank_mapper_with_irq_core.sv
// Cartridge bank mapper with IRQ counter. Each request word carries a kind
// in tuser (CPU write, CPU cycle tick, PRG lookup, CHR lookup) and the
// address and write byte in tdata. Every request yields exactly one response
// word: the looked-up bank and its target, plus the mirroring, IRQ level and
// latch bit as they stand after that request. The block takes one word per
// clock while the response channel does not stall; a word passes the input
// register, then one pass through the register decode, the IRQ tick and the
// lookup into the response register. The CSR port is write-only; writes to
// the wram_present and mirror_at_reset indexes are ignored, as their reset
// values come from package constants, so those writes have no lasting effect.
module rom_bank_mapper_with_irq_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // addr[15:0], data[23:16]
   input  logic [1:0]  req_tuser,    // cmd[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // mapped_bank[8:0], mirror_mode[10:9],
                                     // irq_line[11], latch_bit[12], zero pad
   output logic [1:0]  rsp_tuser,    // target[1:0]
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);
   import rbm_pkg::*;

`include "rom_bank_mapper_with_irq_core_macros.svh"

   // configuration
   logic       extended_mode_ff, extended_mode_in;
   logic [5:0] prg_count_ff, prg_count_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_cmd_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_data_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_bank_ff;
   logic [1:0] rsp_target_ff;
   logic [1:0] rsp_mirror_ff;
   logic       rsp_irq_ff;
   logic       rsp_latch_ff;

   logic          req_accept;
   logic          fire;
   rbm_state_type st, st_next;
   logic [8:0]    lk_bank;
   logic [1:0]    lk_target;

   // the input word moves on whenever the response slot is free or draining
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   // nothing is taken while reset is held
   assign req_tready = !reset && (!in_valid_ff || fire);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      extended_mode_in = extended_mode_ff;
      prg_count_in     = prg_count_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            CSR_EXTENDED_MODE:  extended_mode_in = csr_wdata[0];
            CSR_PRG_BANK_COUNT: prg_count_in     = csr_wdata;
            // reset-value indexes, writes ignored; reset values come from the package
            CSR_WRAM_PRESENT, CSR_MIRROR_AT_RESET: ;
            default: ;
         endcase
      end
   end

   assign in_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         extended_mode_ff <= EXTENDED_MODE_RESET;
         prg_count_ff     <= PRG_BANK_COUNT_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         extended_mode_ff <= extended_mode_in;
         prg_count_ff     <= prg_count_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_tuser;
         in_addr_ff <= req_tdata[15:0];
         in_data_ff <= req_tdata[23:16];
      end
      if (fire) begin
         rsp_bank_ff   <= lk_bank;
         rsp_target_ff <= lk_target;
         rsp_mirror_ff <= st_next.mirroring;
         rsp_irq_ff    <= st_next.irq_pending;
         rsp_latch_ff  <= st_next.ram_latch;
      end
   end

   // mapper registers and irq counter
   rbm_regs u_regs (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .cmd           (in_cmd_ff),
      .addr          (in_addr_ff),
      .data          (in_data_ff),
      .extended_mode (extended_mode_ff),
      .st            (st),
      .st_next       (st_next)
   );

   // lookups read the state before the word, which they never change
   rbm_lookup u_lookup (
      .cmd            (in_cmd_ff),
      .addr           (in_addr_ff),
      .extended_mode  (extended_mode_ff),
      .prg_bank_count (prg_count_ff),
      .st             (st),
      .bank           (lk_bank),
      .target         (lk_target)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_latch_ff, rsp_irq_ff, rsp_mirror_ff, rsp_bank_ff};
   assign rsp_tuser  = rsp_target_ff;

   // a held input word is never overwritten
   `RBM_ASSERT_NEXT(a_in_hold, in_valid_ff && !fire,
      in_valid_ff && $stable(in_addr_ff) && $stable(in_cmd_ff), "input word lost")
   // every processed word shows up as a response
   `RBM_ASSERT_NEXT(a_fire_rsp, fire, rsp_tvalid, "processed word without response")
   // writes and ticks report no bank
   `RBM_ASSERT_NEXT(a_no_bank, fire && (in_cmd_ff == CMD_WRITE || in_cmd_ff == CMD_TICK),
      rsp_bank_ff == 9'd0 && rsp_target_ff == TGT_NONE, "bank reported for non-lookup")
   // the basic variant never raises an interrupt
   `RBM_ASSERT_NEXT(a_basic_no_irq, fire && !extended_mode_ff && !st.irq_pending,
      !st.irq_pending, "irq raised in basic mode")

endmodule

### tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rbm_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 6;
   // the limit covers the slowest run: every word waits out the longest
   // gaps on both sides, plus the long hold-off
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT = 10;

   // fields of one response word as the block should produce them
   typedef struct packed {
      logic [8:0] bank;
      logic [1:0] target;
      logic [1:0] mirror;
      logic       irq;
      logic       latch;
   } rsp_fields_type;

   // mapper state tracker: predicts each response word from the requests
   class bank_map_checker;
      // configuration as last written
      logic       ext;
      logic [5:0] bank_count;
      logic       wram_present_cfg;
      logic [1:0] mirror_reset_cfg;
      // mapper state
      logic [4:0] prg_first, prg_second;
      logic       swap, wram_en;
      logic [1:0] mirror;
      logic [8:0] chr_bank [CHR_BANKS];
      logic [7:0] irq_reload, irq_count;
      logic [9:0] prescale;
      logic       per_tick, irq_en, after_ack, pending, latch;
      rsp_fields_type expected_words [$];
      int mismatches;

      function new();
         ext = EXTENDED_MODE_RESET;
         bank_count = PRG_BANK_COUNT_RESET;
         wram_present_cfg = WRAM_PRESENT_RESET;
         mirror_reset_cfg = MIRROR_AT_RESET_RESET;
         prg_first = '0;
         prg_second = '0;
         swap = 1'b0;
         wram_en = WRAM_PRESENT_RESET;
         mirror = MIRROR_AT_RESET_RESET;
         for (int i = 0; i < CHR_BANKS; i++) chr_bank[i] = 9'(i);
         irq_reload = '0;
         irq_count = '0;
         prescale = '0;
         per_tick = 1'b0;
         irq_en = 1'b0;
         after_ack = 1'b0;
         pending = 1'b0;
         latch = 1'b0;
         mismatches = 0;
      endfunction

      // reset values only matter at reset, which never comes again
      function void set_config(logic [1:0] index, logic [5:0] value);
         case (index)
            CSR_EXTENDED_MODE:  ext = value[0];
            CSR_PRG_BANK_COUNT: bank_count = value;
            CSR_WRAM_PRESENT:   wram_present_cfg = value[0];
            default:            mirror_reset_cfg = value[1:0];
         endcase
      endfunction

      function logic [8:0] fixed_bank(logic [5:0] back);
         return {3'b000, 6'(bank_count - back)};
      endfunction

      function int pending_words();
         return expected_words.size();
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
         rsp_fields_type word;
         logic [1:0] lo;
         logic [3:0] hi_m3;
         logic [2:0] idx;
         logic swapped;
         word = '0;
         word.target = TGT_NONE;
         // address bits 3:2 fold onto 1:0
         lo = addr[1:0] | addr[3:2];
         hi_m3 = addr[15:12] - 4'd3;
         idx = {hi_m3[1:0], lo[1]};
         swapped = ext & swap;
         case (cmd)
            CMD_WRITE: begin
               if (addr >= 16'h6000 && addr < 16'h8000) begin
                  if (!ext) latch = data[0];
               end else if (addr >= 16'h8000) begin
                  case (addr[15:12])
                     4'h8: prg_first = data[4:0];
                     4'hA: prg_second = data[4:0];
                     4'h9: begin
                        if (!ext) begin
                           mirror = {1'b0, data[0]};
                        end else if (lo == 2'd2) begin
                           wram_en = data[0];
                           swap = data[1];
                        end else if (lo < 2'd2) begin
                           mirror = data[1:0];
                        end
                     end
                     4'hF: begin
                        if (ext) begin
                           case (lo)
                              2'd0: irq_reload[3:0] = data[3:0];
                              2'd1: irq_reload[7:4] = data[3:0];
                              2'd2: begin
                                 prescale = PRESCALE_RELOAD;
                                 if (data[1]) irq_count = irq_reload;
                                 per_tick = data[2];
                                 irq_en = data[1];
                                 after_ack = data[0];
                                 pending = 1'b0;
                              end
                              default: begin
                                 irq_en = after_ack;
                                 pending = 1'b0;
                              end
                           endcase
                        end
                     end
                     default: begin
                        if (!lo[0]) chr_bank[idx][3:0] = data[3:0];
                        else chr_bank[idx][8:4] = ext ? data[4:0] : {1'b0, data[3:0]};
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (ext && irq_en) begin
                  prescale = prescale - PRESCALE_STEP;
                  if (per_tick || prescale == 10'd0 || prescale[9]) begin
                     if (irq_count == IRQ_COUNT_WRAP) begin
                        irq_count = irq_reload;
                        pending = 1'b1;
                     end else begin
                        irq_count = irq_count + 8'd1;
                     end
                     prescale = prescale + PRESCALE_RELOAD;
                  end
               end
            end
            CMD_PRG: begin
               word.target = TGT_PRG;
               if (addr < 16'h6000) word.target = TGT_NONE;
               else if (addr < 16'h8000) word.target = wram_en ? TGT_WRAM : TGT_NONE;
               else if (addr < 16'hA000) word.bank = swapped ? fixed_bank(6'd2) : 9'(prg_first);
               else if (addr < 16'hC000) word.bank = 9'(prg_second);
               else if (addr < 16'hE000) word.bank = swapped ? 9'(prg_first) : fixed_bank(6'd2);
               else word.bank = fixed_bank(6'd1);
            end
            default: begin
               if (addr < 16'h2000) begin
                  word.bank = chr_bank[addr[12:10]];
                  word.target = TGT_CHR;
               end
            end
         endcase
         word.mirror = mirror;
         word.irq = pending;
         word.latch = latch;
         expected_words.push_back(word);
      endfunction

      function void check_response(logic [15:0] tdata, logic [1:0] tuser);
         rsp_fields_type got, want;
         got.bank = tdata[8:0];
         got.mirror = tdata[10:9];
         got.irq = tdata[11];
         got.latch = tdata[12];
         got.target = tuser;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response word: tdata %h tuser %h", tdata, tuser);
            return;
         end
         want = expected_words.pop_front();
         if (got.bank !== want.bank || got.target !== want.target ||
             got.mirror !== want.mirror || got.irq !== want.irq ||
             got.latch !== want.latch) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: bank %0d/%0d target %0d/%0d mirror %0d/%0d %s",
                        want.bank, got.bank, want.target, got.target, want.mirror, got.mirror,
                        $sformatf("irq %b/%b latch %b/%b",
                                  want.irq, got.irq, want.latch, got.latch));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // addr[15:0], data[23:16]
   logic [1:0]  req_tuser;    // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // mapped_bank[8:0], mirror_mode[10:9], irq_line[11],
                              // latch_bit[12], zero pad
   logic [1:0]  rsp_tuser;    // target[1:0]
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [5:0]  csr_wdata;

   bank_map_checker map_sb;
   bit idle_on = 1'b0;     // random gaps on both sides when set
   bit hold_req = 1'b0;    // asks the receiver for one long hold-off
   int cycle_count = 0;

   rom_bank_mapper_with_irq_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // both handshakes sampled at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) map_sb.check_response(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            map_sb.note_request(req_tuser, req_tdata[15:0], req_tdata[23:16]);
      end
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: bursts of ready, random stalls, and one long hold-off on request
   initial begin : ready_driver
      int n;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (!idle_on || $urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            n = 1 + pick_gap();
            repeat (n) @(posedge clock);
         end
      end
   end

   // offer one request word and hold it until taken; valid stays up
   // when the next word follows without a gap
   task automatic send_word(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly register-region writes and lookups, some ticks, some noise
   task automatic send_random_item();
      int unsigned r;
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  data;
      r = $urandom_range(0, 99);
      addr = 16'($urandom);
      data = 8'($urandom);
      if (r < 30) begin
         cmd = CMD_TICK;
      end else if (r < 55) begin
         // register window, irq block favored
         cmd = CMD_WRITE;
         addr[15:12] = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(8, 15));
      end else if (r < 62) begin
         cmd = CMD_WRITE;
      end else if (r < 66) begin
         // latch window
         cmd = CMD_WRITE;
         addr = 16'($urandom_range(16'h6000, 16'h7FFF));
      end else if (r < 82) begin
         cmd = CMD_PRG;
      end else begin
         cmd = CMD_CHR;
         if ($urandom_range(0, 4) != 0) addr[15:13] = 3'b000;
      end
      send_word(cmd, addr, data);
   endtask

   // random words in stretches, some with gaps and some without
   task automatic send_random_run(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_random_item();
      end
   endtask

   // prescaler path: reload 0xff, enable without cycle mode, tick past
   // one prescaler period so the counter wraps and raises irq
   task automatic run_prescaler_burst();
      send_word(CMD_WRITE, 16'hF000, 8'h0F);
      send_word(CMD_WRITE, 16'hF001, 8'h0F);
      send_word(CMD_WRITE, 16'hF002, 8'h02);
      repeat (120) send_word(CMD_TICK, 16'($urandom), 8'($urandom));
      send_word(CMD_WRITE, 16'hF003, 8'h00);
   endtask

   // drop valid, wait for every expected word, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (map_sb.pending_words() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [5:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      map_sb.set_config(index, value);
   endtask

   // all four registers back to back; write enable drops after the last
   task automatic write_settings(logic ext, logic [5:0] count, logic wp, logic [1:0] mr);
      write_csr(CSR_EXTENDED_MODE, {5'b00000, ext});
      write_csr(CSR_PRG_BANK_COUNT, count);
      write_csr(CSR_WRAM_PRESENT, {5'b00000, wp});
      write_csr(CSR_MIRROR_AT_RESET, {4'b0000, mr});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : main
      map_sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_WRITE;
      csr_we = 1'b0;
      csr_index = CSR_EXTENDED_MODE;
      csr_wdata = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset settings: extended mode, 32 banks
      idle_on = 1'b0;
      send_word(CMD_PRG, 16'h0000, 8'h00);     // below prg window
      send_word(CMD_PRG, 16'h6000, 8'h00);     // work ram
      send_word(CMD_PRG, 16'h8000, 8'h00);
      send_word(CMD_PRG, 16'hC000, 8'h00);     // second to last fixed bank
      send_word(CMD_PRG, 16'hFFFF, 8'hFF);     // last fixed bank
      send_word(CMD_CHR, 16'h0000, 8'h00);
      send_word(CMD_CHR, 16'h1FFF, 8'h00);
      send_word(CMD_CHR, 16'h2000, 8'h00);     // above chr window
      send_word(CMD_WRITE, 16'h8000, 8'hFF);
      send_word(CMD_WRITE, 16'hAFFF, 8'h15);
      send_word(CMD_WRITE, 16'h9002, 8'h03);   // wram on, swap on
      send_word(CMD_PRG, 16'h8000, 8'h00);     // swapped fixed bank
      send_word(CMD_PRG, 16'hDFFF, 8'h00);
      send_word(CMD_WRITE, 16'h9004, 8'h02);   // folded onto mirroring
      send_word(CMD_WRITE, 16'h9003, 8'hFF);   // ignored
      send_word(CMD_WRITE, 16'h9008, 8'h02);   // folded onto wram and swap
      send_word(CMD_PRG, 16'h7FFF, 8'h00);     // wram disabled
      send_word(CMD_WRITE, 16'hB000, 8'hFF);   // low half of chr 0
      send_word(CMD_WRITE, 16'hE00F, 8'hFF);   // wide high half of chr 7
      send_word(CMD_CHR, 16'h1C00, 8'h00);
      send_word(CMD_WRITE, 16'h6000, 8'h01);   // latch ignored in extended mode
      send_word(CMD_WRITE, 16'h5FFF, 8'hFF);   // below registers
      send_word(CMD_WRITE, 16'hF000, 8'h0F);
      send_word(CMD_WRITE, 16'hF001, 8'h0F);
      send_word(CMD_WRITE, 16'hF002, 8'h07);   // cycle mode, enable, load, ack
      send_word(CMD_TICK, 16'h0000, 8'h00);    // wraps at 0xff
      send_word(CMD_WRITE, 16'hF003, 8'h00);   // acknowledge
      send_word(CMD_CHR, 16'hFFFF, 8'h00);

      send_random_run(120);
      run_prescaler_burst();
      wait_idle();

      // basic variant, reset-value registers written but inert
      write_settings(1'b0, 6'd32, 1'b0, 2'd3);
      send_random_run(120);
      wait_idle();

      // smallest legal bank count
      write_settings(1'b1, 6'd2, 1'b1, 2'd1);
      send_random_run(120);
      run_prescaler_burst();
      wait_idle();

      // basic variant, bank count at the field maximum
      write_settings(1'b0, 6'd63, 1'b1, 2'd2);
      send_random_run(120);
      wait_idle();

      // bank count zero wraps the fixed banks
      write_settings(1'b1, 6'd0, 1'b0, 2'd0);
      send_random_run(120);
      run_prescaler_burst();
      wait_idle();

      // bank count one, then the long receiver hold-off with a full sender
      write_settings(1'b1, 6'd1, 1'b1, 2'd3);
      send_random_run(100);
      idle_on = 1'b0;
      hold_req = 1'b1;
      repeat (120) send_random_item();
      send_random_run(50);
      wait_idle();

      if (map_sb.mismatches == 0 && map_sb.pending_words() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/rbm_pkg.sv
sv/rbm_regs.sv
sv/rbm_lookup.sv
sv/rom_bank_mapper_with_irq_core.sv
tb/tb_top.sv
